// ----- sv/dtbm_pkg.sv -----
// Shared constants, codes and types of the table-driven DFA byte matcher.
package dtbm_pkg;

  // Table geometry
  localparam int MAX_STATES  = 256;
  localparam int MAX_TARGETS = 65536;
  localparam int ROWS        = (MAX_STATES < 256) ? MAX_STATES : 256;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TBL_DEPTH   = ROWS * 256;
  localparam int ADDR_W      = ROW_W + 8;

  // Field widths
  localparam int CODE_W  = 17;
  localparam int CNT_W   = 9;
  localparam int VAL_W   = 32;
  localparam int STATE_W = 8;

  // Unsigned copies for compares against signals
  localparam logic [31:0] MAX_STATES_L  = 32'(MAX_STATES);
  localparam logic [31:0] MAX_TARGETS_L = 32'(MAX_TARGETS);
  localparam logic [31:0] ROWS_L        = 32'(ROWS);

  // Item kind carried in tuser
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_MATCH = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_STATE_COUNT = 2'd0,
    CFG_DEFAULT     = 2'd1
  } cfg_idx_e;

  // Per-string matching context
  typedef struct packed {
    logic [STATE_W-1:0] dfa_state;
    logic               decided;
    logic [VAL_W-1:0]   held_value;
    logic               held_matched;
  } ctx_t;

  // Item sitting in the table-read stage
  typedef struct packed {
    logic valid;
    logic match;
    logic eos;
  } stage_t;

  // String result
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             matched;
  } res_t;

endpackage

// ----- sv/dfa_table_byte_matcher_top.sv -----
// Top level of the table-driven DFA byte matcher.
//
// The matcher takes one item per clock cycle. A write item stores one
// transition code at (row_state, byte_value); a match item reads the entry at
// (current state, byte) from the single-port table RAM, and the returned code
// gives the next state or decides the string, in the cycle after the item is
// transferred. The loop from the registered RAM output through the next-state
// compare back to the RAM address sets the rate of one byte per cycle. The
// match item with tlast gives one result on the master side through an output
// register; only that item waits while an earlier result is still untaken.
// The table RAM has no reset: an entry must be written before a match reads it.
module dfa_table_byte_matcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row_state[7:0], byte_value[15:8], entry_code[32:16]
  input  logic        s_axis_tuser,   // op[0]
  input  logic        s_axis_tlast,   // end_of_string
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_value[31:0]
  output logic        m_axis_tuser    // matched[0]
);
  import dtbm_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0] count_q;
  logic [VAL_W-1:0] default_q;

  // Context, read stage and output register
  ctx_t             ctx_q, ctx_d;
  stage_t           stage_q, stage_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;
  res_t             res;

  // Table port
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [CODE_W-1:0] ram_rdata;

  // Input fields
  logic [STATE_W-1:0] in_row;
  logic [7:0]         in_byte;
  logic [CODE_W-1:0]  in_code;
  logic               accept, stage_fire, stage_result, out_free;

  assign in_row  = s_axis_tdata[7:0];
  assign in_byte = s_axis_tdata[15:8];
  assign in_code = s_axis_tdata[32:16];

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      default_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STATE_COUNT: count_q   <= cfg_data_i[CNT_W-1:0];
        CFG_DEFAULT:     default_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Entry processing for the item in the read stage
  dtbm_step u_step (
    .ctx_i     (ctx_q),
    .stage_i   (stage_q),
    .count_i   (count_q),
    .default_i (default_q),
    .code_i    (ram_rdata),
    .ctx_o     (ctx_d),
    .res_o     (res)
  );

  // Flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign stage_result  = stage_q.valid && stage_q.match && stage_q.eos;
  assign stage_fire    = stage_q.valid && (!stage_result || out_free);
  assign s_axis_tready = !stage_q.valid || stage_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Table access: writes by row, reads by the state after the staged byte
  assign ram_we   = accept && (op_e'(s_axis_tuser) == OP_WRITE)
                 && ({24'b0, in_row} < ROWS_L);
  assign ram_re   = accept && (op_e'(s_axis_tuser) == OP_MATCH);
  assign ram_addr = ram_we ? {in_row[ROW_W-1:0], in_byte}
                           : {ctx_d.dfa_state[ROW_W-1:0], in_byte};

  dtbm_ram #(
    .Depth (TBL_DEPTH),
    .Width (CODE_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_code),
    .rdata_o (ram_rdata)
  );

  // Read stage contents
  always_comb begin
    stage_d = stage_q;
    if (accept) begin
      stage_d.valid = 1'b1;
      stage_d.match = (op_e'(s_axis_tuser) == OP_MATCH);
      stage_d.eos   = s_axis_tlast;
    end else if (stage_fire) begin
      stage_d.valid = 1'b0;
    end
  end

  assign out_valid_d = (stage_fire && stage_result) || (out_valid_q && !m_axis_tready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q       <= '0;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
      if (stage_fire) begin
        ctx_q <= ctx_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (stage_fire && stage_result) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.matched;

  // A terminating byte leaves the matcher at the start state, undecided
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_fire && stage_result) |=> (ctx_q.dfa_state == '0 && !ctx_q.decided))
    else $error("context not restarted after end of string");

  // A result appears only after a terminating match byte completed
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stage_fire && stage_result))
    else $error("result without a terminating match byte");

  // The staged item holds while the output register blocks it
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q.valid && !stage_fire) |=> (stage_q.valid && $stable(stage_q)))
    else $error("staged item lost under stall");

endmodule

// ----- sv/dtbm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
module dtbm_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dtbm_step.sv -----
// Next-state and decision logic applied to one table entry.
module dtbm_step (
  input  dtbm_pkg::ctx_t                 ctx_i,
  input  dtbm_pkg::stage_t               stage_i,
  input  logic [dtbm_pkg::CNT_W-1:0]     count_i,
  input  logic [dtbm_pkg::VAL_W-1:0]     default_i,
  input  logic [dtbm_pkg::CODE_W-1:0]    code_i,
  output dtbm_pkg::ctx_t                 ctx_o,
  output dtbm_pkg::res_t                 res_o
);
  import dtbm_pkg::*;

  logic [CNT_W-1:0]  live_n;
  logic [CODE_W-1:0] live_n_ext;
  logic [CODE_W-1:0] offset;
  logic [CODE_W-1:0] target;
  logic              stale;
  logic              fail;
  ctx_t              byte_ctx;

  // Clamp the loaded state count
  assign live_n     = ({23'b0, count_i} > MAX_STATES_L) ? CNT_W'(MAX_STATES) : count_i;
  assign live_n_ext = {{(CODE_W-CNT_W){1'b0}}, live_n};

  // Current state no longer inside the loaded table
  assign stale = ({1'b0, ctx_i.dfa_state} >= live_n)
              || ({24'b0, ctx_i.dfa_state} >= ROWS_L);

  // Decision code split
  assign offset = code_i - live_n_ext;
  assign target = offset - CODE_W'(1);
  assign fail   = (offset == '0) || ({15'b0, target} >= MAX_TARGETS_L);

  // Apply the byte
  always_comb begin
    byte_ctx = ctx_i;
    if (stage_i.valid && stage_i.match && !ctx_i.decided && (live_n != '0)) begin
      if (stale) begin
        byte_ctx.decided      = 1'b1;
        byte_ctx.held_value   = default_i;
        byte_ctx.held_matched = 1'b0;
      end else if (code_i < live_n_ext) begin
        byte_ctx.dfa_state = code_i[STATE_W-1:0];
      end else begin
        byte_ctx.decided = 1'b1;
        if (fail) begin
          byte_ctx.held_value   = default_i;
          byte_ctx.held_matched = 1'b0;
        end else begin
          byte_ctx.held_value   = {15'b0, target};
          byte_ctx.held_matched = 1'b1;
        end
      end
    end
  end

  // Result of the string and restart on its terminating byte
  always_comb begin
    if (byte_ctx.decided) begin
      res_o.value   = byte_ctx.held_value;
      res_o.matched = byte_ctx.held_matched;
    end else begin
      res_o.value   = default_i;
      res_o.matched = 1'b0;
    end
    ctx_o = byte_ctx;
    if (stage_i.valid && stage_i.match && stage_i.eos) begin
      ctx_o.dfa_state = '0;
      ctx_o.decided   = 1'b0;
    end
  end

endmodule
